>>> rtl/core/pack_charge_mode_controller_assert.svh
// ----------------------------------------------------------------------------
// Pack charge mode controller assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACK_CHARGE_MODE_CONTROLLER_ASSERT_SVH
`define PACK_CHARGE_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define PCMC_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("pcmc assertion failed");

// next-cycle implication
`define PCMC_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("pcmc assertion failed");

`endif

>>> rtl/core/pcmc_pkg.sv
// ----------------------------------------------------------------------------
// Pack charge mode controller package
// Codes, word types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pcmc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned REG_W      = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned DIV_NUM_W  = 32;
	localparam int unsigned DIV_DEN_W  = 16;
	localparam int unsigned DIV_CNT_W  = 4;

	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_CHARGE  = 2'd1;
	localparam logic [1:0] CMD_BALANCE = 2'd2;
	localparam logic [1:0] CMD_IDLE    = 2'd3;

	localparam logic [1:0] ST_IDLE      = 2'd0;
	localparam logic [1:0] ST_CHARGING  = 2'd1;
	localparam logic [1:0] ST_BALANCING = 2'd2;

	localparam logic [1:0] MODE_CC    = 2'd0;
	localparam logic [1:0] MODE_TAPER = 2'd1;
	localparam logic [1:0] MODE_MAINT = 2'd2;
	localparam logic [1:0] MODE_BAL   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_V  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_I  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAINT_I  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_IMB  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd6;

	localparam logic [REG_W-1:0] RST_LIMIT_V = 16'd0;
	localparam logic [REG_W-1:0] RST_LIMIT_I = 16'd0;
	localparam logic [REG_W-1:0] RST_MAINT_I = 16'd10;
	localparam logic [REG_W-1:0] RST_UPPER   = 16'd4150;
	localparam logic [REG_W-1:0] RST_LOWER   = 16'd4100;
	localparam logic [REG_W-1:0] RST_MIN_IMB = 16'd20;
	localparam logic [REG_W-1:0] RST_HOLD    = 16'd2000;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] now_ms;
		logic [REG_W-1:0]  max_cell_mv;
		logic [REG_W-1:0]  imbalance_mv;
		logic [REG_W-1:0]  pack_sum_cv;
		logic [4:0]        charger_faults;
		logic [7:0]        bms_faults;
		logic              estop_ok;
		logic              terminal_loop_ok;
		logic              accum_loop_ok;
		logic              hv_switch_on;
		logic              ready_pin;
	} in_word_t;

	typedef struct packed {
		logic             charge_cmd_valid;
		logic             charge_enable;
		logic [REG_W-1:0] charge_voltage_dv;
		logic [REG_W-1:0] charge_current_da;
		logic             balance_enable;
		logic             balance_led;
		logic             hv_led;
		logic [1:0]       charger_state_out;
		logic [1:0]       charge_mode_out;
		logic             show_errors;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic mul;
		logic div_start;
		logic take_quo;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic taper;
		logic div_done;
	} dp_status_t;

endpackage

>>> rtl/core/pcmc_div.sv
// ----------------------------------------------------------------------------
// Pack charge mode controller divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pcmc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pcmc_pkg::DIV_NUM_W-1:0]   dividend,
	input  logic [pcmc_pkg::DIV_DEN_W-1:0]   divisor,
	output logic [pcmc_pkg::DIV_NUM_W-1:0]   quotient,
	output logic                             done
);
	import pcmc_pkg::*;

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = {DIV_CNT_W{1'b1}};

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0]   t1, t2;
	logic                 ge1, ge2;
	logic [DIV_DEN_W:0]   r1, r2;
	logic [DIV_NUM_W-1:0] q1, q2;

	always_comb begin
		t1  = {rem_q, quo_q[DIV_NUM_W-1]};
		ge1 = t1 >= {1'b0, den_q};
		r1  = ge1 ? (t1 - {1'b0, den_q}) : t1;
		q1  = {quo_q[DIV_NUM_W-2:0], ge1};
		t2  = {r1[DIV_DEN_W-1:0], q1[DIV_NUM_W-1]};
		ge2 = t2 >= {1'b0, den_q};
		r2  = ge2 ? (t2 - {1'b0, den_q}) : t2;
		q2  = {q1[DIV_NUM_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= q2;
			rem_q <= r2[DIV_DEN_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> rtl/core/pcmc_dp.sv
// ----------------------------------------------------------------------------
// Pack charge mode controller datapath
// Registers, charger state, safety and fault checks, mode pick and taper math.
// ----------------------------------------------------------------------------
module pcmc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pcmc_pkg::in_word_t               in_word,
	input  logic                             cfg_we,
	input  logic [pcmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcmc_pkg::REG_W-1:0]       cfg_wdata,
	input  pcmc_pkg::ctrl_cmd_t              cmd,
	output pcmc_pkg::dp_status_t             status,
	output pcmc_pkg::out_word_t              out_word
);
	import pcmc_pkg::*;

	localparam logic [REG_W-1:0] RECIP10 = 16'd52429;
	localparam int unsigned      RECIP_SH = 19;

	in_word_t  in_q;
	out_word_t res_q;
	out_word_t out_q;
	out_word_t res;

	logic [REG_W-1:0] limit_v_q, limit_i_q, maint_i_q, upper_q, lower_q, min_imb_q, hold_q;

	logic [1:0]        state_q;
	logic [1:0]        mode_q;
	logic              was_faulting_q;
	logic [TIME_W-1:0] fault_start_q;
	logic              hv_lamp_q;

	logic [1:0]        st_cmd;
	logic              active, charging, safe, ready, ok, faulting, check, persist;
	logic              shutdown, run, hv_new;
	logic [TIME_W-1:0] start_new, elapsed;
	logic [1:0]        mode_pick;
	logic [RECIP_SH+REG_W-1:0] div10_full;

	logic signed [REG_W:0]     diff_a, diff_b;
	logic signed [2*REG_W+1:0] prod_full;
	logic signed [2*REG_W+1:0] prod_q;
	logic [2*REG_W+1:0]        mag_full;
	logic                      neg;

	logic [DIV_NUM_W-1:0] quotient;
	logic                 div_done;
	logic [REG_W-1:0]     den;

	logic signed [DIV_NUM_W+1:0] q_ext, c_full;
	logic [REG_W-1:0]            c_sat;

	always_comb begin
		unique case (in_q.command)
			CMD_CHARGE:  st_cmd = ST_CHARGING;
			CMD_BALANCE: st_cmd = ST_BALANCING;
			CMD_IDLE:    st_cmd = ST_IDLE;
			default:     st_cmd = state_q;
		endcase
	end

	always_comb begin
		charging  = st_cmd == ST_CHARGING;
		active    = charging || (st_cmd == ST_BALANCING);
		safe      = in_q.estop_ok & in_q.terminal_loop_ok & in_q.accum_loop_ok;
		ready     = !in_q.ready_pin;
		ok        = charging ? (safe & in_q.hv_switch_on & ready) : (safe & ready);
		hv_new    = (charging & safe) ? in_q.hv_switch_on : hv_lamp_q;
		faulting  = (|in_q.charger_faults) | (|in_q.bms_faults);
		check     = active & ok;
		start_new = (faulting & !was_faulting_q) ? in_q.now_ms : fault_start_q;
		elapsed   = in_q.now_ms - start_new;
		persist   = faulting && (elapsed >= {{(TIME_W-REG_W){1'b0}}, hold_q});
		shutdown  = active & (!ok | persist);
		run       = active & !shutdown;
	end

	always_comb begin
		priority if (st_cmd == ST_BALANCING) begin
			mode_pick = MODE_BAL;
		end else if (in_q.max_cell_mv >= upper_q) begin
			mode_pick = (in_q.imbalance_mv >= min_imb_q) ? MODE_BAL : MODE_MAINT;
		end else if (in_q.max_cell_mv >= lower_q) begin
			mode_pick = MODE_TAPER;
		end else begin
			mode_pick = MODE_CC;
		end
	end

	assign div10_full = in_q.pack_sum_cv * RECIP10;

	always_comb begin
		res = '0;
		res.hv_led            = hv_new;
		res.charger_state_out = shutdown ? ST_IDLE : st_cmd;
		res.charge_mode_out   = run ? mode_pick : mode_q;
		if (shutdown) begin
			res.charge_cmd_valid  = 1'b1;
			res.charge_voltage_dv = limit_v_q;
			res.charge_current_da = limit_i_q;
			res.show_errors       = 1'b1;
		end else if (run) begin
			res.charge_cmd_valid  = 1'b1;
			res.charge_voltage_dv = limit_v_q;
			res.charge_current_da = limit_i_q;
			if (mode_pick == MODE_BAL) begin
				res.balance_enable = 1'b1;
				res.balance_led    = 1'b1;
			end else if (charging) begin
				res.charge_enable = 1'b1;
				if (mode_pick == MODE_MAINT) begin
					res.charge_voltage_dv = div10_full[RECIP_SH +: REG_W];
					res.charge_current_da = maint_i_q;
				end
			end
		end
	end

	assign status.taper    = run & charging & (mode_pick == MODE_TAPER);
	assign status.div_done = div_done;

	// taper: limit + (maint - limit) * (max_cell - lower) / (upper - lower)
	assign diff_a    = $signed({1'b0, maint_i_q}) - $signed({1'b0, limit_i_q});
	assign diff_b    = $signed({1'b0, in_q.max_cell_mv - lower_q});
	assign prod_full = diff_a * diff_b;
	assign neg       = prod_q[2*REG_W+1];
	assign mag_full  = neg ? (-prod_q) : prod_q;
	assign den       = upper_q - lower_q;

	pcmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag_full[DIV_NUM_W-1:0]),
		.divisor  (den),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		q_ext  = $signed({2'b00, quotient});
		c_full = $signed({{(DIV_NUM_W+2-REG_W){1'b0}}, limit_i_q}) + (neg ? -q_ext : q_ext);
		priority if (c_full < 0) begin
			c_sat = '0;
		end else if (c_full > $signed({{(DIV_NUM_W+2-REG_W){1'b0}}, {REG_W{1'b1}}})) begin
			c_sat = '1;
		end else begin
			c_sat = c_full[REG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_v_q <= RST_LIMIT_V;
			limit_i_q <= RST_LIMIT_I;
			maint_i_q <= RST_MAINT_I;
			upper_q   <= RST_UPPER;
			lower_q   <= RST_LOWER;
			min_imb_q <= RST_MIN_IMB;
			hold_q    <= RST_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIMIT_V: limit_v_q <= cfg_wdata;
				CFG_LIMIT_I: limit_i_q <= cfg_wdata;
				CFG_MAINT_I: maint_i_q <= cfg_wdata;
				CFG_UPPER:   upper_q   <= cfg_wdata;
				CFG_LOWER:   lower_q   <= cfg_wdata;
				CFG_MIN_IMB: min_imb_q <= cfg_wdata;
				CFG_HOLD:    hold_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mode_q         <= MODE_CC;
			was_faulting_q <= 1'b0;
			fault_start_q  <= '0;
			hv_lamp_q      <= 1'b0;
		end else if (cmd.eval) begin
			state_q   <= res.charger_state_out;
			mode_q    <= res.charge_mode_out;
			hv_lamp_q <= hv_new;
			if (check) begin
				was_faulting_q <= faulting;
				fault_start_q  <= start_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_word;
		end
		if (cmd.mul) begin
			prod_q <= prod_full;
		end
		if (cmd.eval) begin
			res_q <= res;
		end else if (cmd.take_quo) begin
			res_q.charge_current_da <= c_sat;
		end
		if (cmd.load) begin
			out_q <= res_q;
		end
	end

	assign out_word = out_q;

endmodule

>>> rtl/core/pcmc_ctrl.sv
// ----------------------------------------------------------------------------
// Pack charge mode controller sequencer
// Steps one tick through evaluate, taper multiply and divide (taper ticks only), and output load.
// ----------------------------------------------------------------------------
`include "pack_charge_mode_controller_assert.svh"

module pcmc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  pcmc_pkg::dp_status_t status,
	output pcmc_pkg::ctrl_cmd_t  cmd
);
	import pcmc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.eval      = state_q == S_EVAL;
		cmd.mul       = state_q == S_MUL;
		cmd.div_start = state_q == S_DIV;
		cmd.take_quo  = (state_q == S_WAIT) && status.div_done;
		cmd.load      = (state_q == S_FIN) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EVAL;
			S_EVAL: state_d = status.taper ? S_MUL : S_FIN;
			S_MUL:  state_d = S_DIV;
			S_DIV:  state_d = S_WAIT;
			S_WAIT: if (status.div_done) state_d = S_FIN;
			S_FIN:  if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	`PCMC_ASSERT_NEXT(a_accept_eval, in_valid && !in_stall, state_q == S_EVAL)
	`PCMC_ASSERT_NOW(a_done_in_wait, status.div_done, state_q == S_WAIT)
	`PCMC_ASSERT_NEXT(a_taper_mul, state_q == S_EVAL && status.taper, state_q == S_MUL)

endmodule

>>> rtl/core/pack_charge_mode_controller.sv
// ----------------------------------------------------------------------------
// Pack charge mode controller
// Charger state, charge mode selection, fault hold and HV lamp per control tick.
//
//   port group   direction   handshake            payload
//   in_word      in          in_valid / in_stall    pcmc_pkg::in_word_t
//   out_word     out         out_valid / out_stall  pcmc_pkg::out_word_t
//   cfg          in          cfg_we                 cfg_index, cfg_wdata
//
// One word at a time. A taper tick also passes through the multiply and the
// divider, which takes two quotient bits a cycle. A finished word waits in the
// output register while the next one is taken. Reset is asynchronous; control
// and config registers take their defaults, no clearing pass.
// ----------------------------------------------------------------------------
module pack_charge_mode_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  pcmc_pkg::in_word_t               in_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pcmc_pkg::out_word_t              out_word,
	input  logic                             cfg_we,
	input  logic [pcmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcmc_pkg::REG_W-1:0]       cfg_wdata
);
	import pcmc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	pcmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pcmc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.out_word  (out_word)
	);

endmodule
